// ===== sv/card_pkg.sv =====
// Types and constants shared by the result-link deframer.
package card_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned LEN_W     = 16;
   localparam int unsigned KIND_W    = 3;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned MAX_RES   = 3;

   localparam logic [BYTE_W-1:0] HDR_NORMAL = 8'h01;
   localparam logic [BYTE_W-1:0] HDR_EXCEPT = 8'h02;
   localparam logic [BYTE_W-1:0] ACK_START  = 8'h21;
   localparam logic [BYTE_W-1:0] ACK_CHUNK  = 8'h23;

   localparam logic [BYTE_W-1:0] TIMEOUT_RESET = 8'd20;
   localparam logic [BYTE_W-1:0] CHUNK_RESET   = 8'd100;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK   = 1'b1;

   localparam logic [KIND_W-1:0] KIND_CONSOLE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ACK     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DONE    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd4;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_DATA
   } phase_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] value;
      logic              exception;
      logic              last;
   } result_type;

   typedef struct packed {
      logic [1:0]                 count;
      result_type [MAX_RES-1:0]   item;
   } push_type;

endpackage

// ===== sv/card_if.sv =====
// Channel interfaces for request items, result items and register writes.
interface card_req_if
   import card_pkg::*;
;
   logic              valid;
   logic              ready;
   logic              op;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface card_rsp_if
   import card_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] value;
   logic              exception;
   logic              last;

   modport source (output valid, output kind, output value, output exception,
                   output last, input ready);
   modport sink (input valid, input kind, input value, input exception,
                 input last, output ready);
endinterface

interface card_csr_if
   import card_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [BYTE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/chunked_ack_result_deframer.sv =====
// Top level of the result-link deframer: frame tracking and result queue.
// Result items go into the result queue and are offered on rsp in the order they were made.
// Throughput: one item per cycle while items give at most one result each and rsp takes
// them; the four-entry result queue holds req ready low until three places are free.
// Reset: synchronous, clears frame state and queue; timeout 20 and chunk size 100.
module chunked_ack_result_deframer
   import card_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   card_req_if.sink   req_bus,
   card_rsp_if.source rsp_bus,
   card_csr_if.sink   csr_bus
);

   phase_type          phase_ff, phase_in;
   logic               exc_ff, exc_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   rcvd_ff, rcvd_in;
   logic [BYTE_W-1:0]  chunk_ff, chunk_in;
   logic [BYTE_W-1:0]  idle_ff, idle_in;
   logic [BYTE_W-1:0]  timeout_ff, chunk_size_ff;

   logic               accept;
   logic               space;
   push_type           push_data;
   logic [LEN_W-1:0]   rcvd_inc;
   logic [BYTE_W-1:0]  chunk_inc;
   logic [BYTE_W-1:0]  idle_sat;
   logic               timed_out;
   logic               last_byte;
   logic               chunk_hit;
   logic               len_zero;
   logic [1:0]         n;

   assign accept  = req_bus.valid && req_bus.ready;
   assign req_bus.ready = space;
   assign csr_bus.ready = 1'b1;

   assign rcvd_inc  = rcvd_ff + LEN_W'(1);
   assign chunk_inc = chunk_ff + BYTE_W'(1);
   assign idle_sat  = (idle_ff == '1) ? idle_ff : idle_ff + BYTE_W'(1);
   assign timed_out = (timeout_ff != '0) && (idle_sat >= timeout_ff);
   assign last_byte = (rcvd_inc == len_ff);
   assign chunk_hit = (chunk_inc == chunk_size_ff) || last_byte;
   assign len_zero  = ({len_ff[LEN_W-1:BYTE_W], req_bus.rx_byte} == '0);

   // next state
   always_comb begin
      phase_in = phase_ff;
      exc_in   = exc_ff;
      len_in   = len_ff;
      rcvd_in  = rcvd_ff;
      chunk_in = chunk_ff;
      idle_in  = idle_ff;
      if (req_bus.op == OP_TICK) begin
         if (phase_ff != PH_IDLE) begin
            idle_in = idle_sat;
            if (timed_out) begin
               phase_in = PH_IDLE;
               len_in   = '0;
               rcvd_in  = '0;
               chunk_in = '0;
               idle_in  = '0;
            end
         end
      end else begin
         idle_in = '0;
         case (phase_ff)
            PH_IDLE: begin
               if (req_bus.rx_byte == HDR_NORMAL || req_bus.rx_byte == HDR_EXCEPT) begin
                  exc_in   = (req_bus.rx_byte == HDR_EXCEPT);
                  len_in   = '0;
                  rcvd_in  = '0;
                  chunk_in = '0;
                  phase_in = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               len_in   = {req_bus.rx_byte, BYTE_W'(0)};
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               if (len_zero) begin
                  phase_in = PH_IDLE;
                  len_in   = '0;
               end else begin
                  len_in   = {len_ff[LEN_W-1:BYTE_W], req_bus.rx_byte};
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               rcvd_in  = rcvd_inc;
               chunk_in = chunk_hit ? '0 : chunk_inc;
               if (last_byte) begin
                  phase_in = PH_IDLE;
                  len_in   = '0;
                  rcvd_in  = '0;
                  chunk_in = '0;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // result items
   always_comb begin
      n         = 2'd0;
      push_data = '0;
      if (req_bus.op == OP_TICK) begin
         if (phase_ff != PH_IDLE && timed_out) begin
            push_data.item[0] = '{KIND_TIMEOUT, '0, exc_ff, 1'b0};
            n = 2'd1;
         end
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               if (req_bus.rx_byte != HDR_NORMAL && req_bus.rx_byte != HDR_EXCEPT) begin
                  push_data.item[0] = '{KIND_CONSOLE, req_bus.rx_byte, 1'b0, 1'b0};
                  n = 2'd1;
               end
            end
            PH_LEN_HI: begin
               n = 2'd0;
            end
            PH_LEN_LO: begin
               push_data.item[0] = '{KIND_ACK, ACK_START, exc_ff, 1'b0};
               n = 2'd1;
               if (len_zero) begin
                  push_data.item[1] = '{KIND_DONE, '0, exc_ff, 1'b0};
                  n = 2'd2;
               end
            end
            PH_DATA: begin
               push_data.item[0] = '{KIND_PAYLOAD, req_bus.rx_byte, exc_ff, 1'b0};
               n = 2'd1;
               if (chunk_hit) begin
                  push_data.item[1] = '{KIND_ACK, ACK_CHUNK, exc_ff, 1'b0};
                  n = 2'd2;
               end
               if (last_byte) begin
                  push_data.item[2] = '{KIND_DONE, '0, exc_ff, 1'b0};
                  n = 2'd3;
               end
            end
            default: begin
               n = 2'd0;
            end
         endcase
      end
      case (n)
         2'd1:    push_data.item[0].last = 1'b1;
         2'd2:    push_data.item[1].last = 1'b1;
         2'd3:    push_data.item[2].last = 1'b1;
         default: push_data.item[0].last = 1'b0;
      endcase
      push_data.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         exc_ff   <= 1'b0;
         len_ff   <= '0;
         rcvd_ff  <= '0;
         chunk_ff <= '0;
         idle_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         exc_ff   <= exc_in;
         len_ff   <= len_in;
         rcvd_ff  <= rcvd_in;
         chunk_ff <= chunk_in;
         idle_ff  <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RESET;
         chunk_size_ff <= CHUNK_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_TIMEOUT: timeout_ff    <= csr_bus.data;
            CSR_CHUNK:   chunk_size_ff <= csr_bus.data;
            default:     timeout_ff    <= timeout_ff;
         endcase
      end
   end

   card_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (push_data),
      .space     (space),
      .rsp       (rsp_bus)
   );

   a_idle_no_ticks: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (idle_ff == '0))
      else $error("idle tick count set outside a frame");

   a_data_below_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (rcvd_ff < len_ff))
      else $error("payload count reached frame length without ending the frame");

   a_timeout_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.op == OP_TICK && phase_ff != PH_IDLE && timed_out)
      |=> (phase_ff == PH_IDLE && rcvd_ff == '0))
      else $error("timeout did not return to idle");

   a_len_only_in_frame: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE || phase_ff == PH_LEN_HI) |-> (len_ff == '0 && rcvd_ff == '0))
      else $error("frame counters not clear before length");

endmodule

// ===== sv/card_rsp_queue.sv =====
// Result queue: takes up to three result items at once, delivers one per cycle while rsp is ready.
module card_rsp_queue
   import card_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  push_type   push_data,
   output logic       space,
   card_rsp_if.source rsp
);

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PTR_W = $clog2(DEPTH);

   result_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ff, wr_in;
   logic [PTR_W-1:0]       rd_ff, rd_in;
   logic [PTR_W:0]         count_ff, count_in;
   logic                   pop;
   logic [1:0]             n_push;

   assign n_push = push ? push_data.count : 2'd0;
   assign pop    = rsp.valid && rsp.ready;
   assign space  = (count_ff <= (PTR_W + 1)'(DEPTH - MAX_RES));

   assign wr_in    = wr_ff + PTR_W'(n_push);
   assign rd_in    = rd_ff + PTR_W'(pop);
   assign count_in = count_ff + (PTR_W + 1)'(n_push) - (PTR_W + 1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RES; i++) begin
         if (i < int'(n_push)) begin
            entry_ff[wr_ff + PTR_W'(i)] <= push_data.item[i];
         end
      end
   end

   assign rsp.valid     = (count_ff != '0);
   assign rsp.kind      = entry_ff[rd_ff].kind;
   assign rsp.value     = entry_ff[rd_ff].value;
   assign rsp.exception = entry_ff[rd_ff].exception;
   assign rsp.last      = entry_ff[rd_ff].last;

endmodule

// ===== test/tb_chunked_ack_result_deframer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the result-link deframer: directed frames, then random traffic.
module tb_chunked_ack_result_deframer;
   import card_pkg::*;

   localparam int CYCLE_LIMIT = 100000;
   localparam int PHASE_ITEMS = 22;

   logic clock;
   logic reset;

   card_req_if req_bus ();
   card_rsp_if rsp_bus ();
   card_csr_if csr_bus ();

   chunked_ack_result_deframer u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   result_type        results_due [$];
   int                error_count = 0;
   int                cycle_count = 0;
   int                item_count  = 0;
   int                gap_pct     = 0;
   int                stall_pct   = 0;

   logic [BYTE_W-1:0] cfg_timeout = TIMEOUT_RESET;
   logic [BYTE_W-1:0] cfg_chunk   = CHUNK_RESET;
   phase_type         ph          = PH_IDLE;
   logic              exc_flag    = 1'b0;
   logic [LEN_W-1:0]  frame_len   = '0;
   logic [LEN_W-1:0]  rcvd        = '0;
   logic [BYTE_W-1:0] chunk_cnt   = '0;
   logic [BYTE_W-1:0] idle_cnt    = '0;

   always #6 clock = ~clock;

   always @(negedge clock) rsp_bus.ready = ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (results_due.size() == 0) begin
            $display("%0t: unexpected result: kind %0d value %02h exception %0b last %0b",
                     $time, rsp_bus.kind, rsp_bus.value, rsp_bus.exception, rsp_bus.last);
            error_count++;
         end else begin
            want = results_due.pop_front();
            if (rsp_bus.kind !== want.kind || rsp_bus.value !== want.value ||
                rsp_bus.exception !== want.exception || rsp_bus.last !== want.last) begin
               $display("%0t: expected kind %0d value %02h exception %0b last %0b",
                        $time, want.kind, want.value, want.exception, want.last);
               $display("%0t:   actual kind %0d value %02h exception %0b last %0b",
                        $time, rsp_bus.kind, rsp_bus.value, rsp_bus.exception,
                        rsp_bus.last);
               error_count++;
            end
         end
      end
   end

   task automatic return_to_idle();
      ph        = PH_IDLE;
      frame_len = '0;
      rcvd      = '0;
      chunk_cnt = '0;
      idle_cnt  = '0;
   endtask

   task automatic advance_deframer(input logic op, input logic [BYTE_W-1:0] b);
      result_type made [MAX_RES];
      int         n;
      n = 0;
      if (op == OP_TICK) begin
         if (ph != PH_IDLE) begin
            if (idle_cnt != 8'hFF) idle_cnt++;
            if (cfg_timeout != 0 && idle_cnt >= cfg_timeout) begin
               made[n] = '{KIND_TIMEOUT, 8'h00, exc_flag, 1'b0};
               n++;
               return_to_idle();
            end
         end
      end else begin
         idle_cnt = '0;
         case (ph)
            PH_IDLE: begin
               if (b == HDR_NORMAL || b == HDR_EXCEPT) begin
                  exc_flag  = (b == HDR_EXCEPT);
                  frame_len = '0;
                  rcvd      = '0;
                  chunk_cnt = '0;
                  ph        = PH_LEN_HI;
               end else begin
                  made[n] = '{KIND_CONSOLE, b, 1'b0, 1'b0};
                  n++;
               end
            end
            PH_LEN_HI: begin
               frame_len = {b, 8'h00};
               ph        = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               frame_len = frame_len | LEN_W'(b);
               made[n] = '{KIND_ACK, ACK_START, exc_flag, 1'b0};
               n++;
               if (frame_len == 0) begin
                  made[n] = '{KIND_DONE, 8'h00, exc_flag, 1'b0};
                  n++;
                  return_to_idle();
               end else begin
                  ph = PH_DATA;
               end
            end
            default: begin
               made[n] = '{KIND_PAYLOAD, b, exc_flag, 1'b0};
               n++;
               rcvd++;
               chunk_cnt++;
               if (chunk_cnt == cfg_chunk || rcvd == frame_len) begin
                  made[n] = '{KIND_ACK, ACK_CHUNK, exc_flag, 1'b0};
                  n++;
                  chunk_cnt = '0;
               end
               if (rcvd == frame_len) begin
                  made[n] = '{KIND_DONE, 8'h00, exc_flag, 1'b0};
                  n++;
                  return_to_idle();
               end
            end
         endcase
      end
      for (int i = 0; i < n; i++) begin
         made[i].last = (i == n - 1);
         results_due.push_back(made[i]);
      end
   endtask

   task automatic send_item(input logic op, input logic [BYTE_W-1:0] b);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid   = 1'b1;
      req_bus.op      = op;
      req_bus.rx_byte = b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      item_count++;
      advance_deframer(op, b);
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      send_item(OP_BYTE, b);
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(OP_TICK, BYTE_W'($urandom_range(255)));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [BYTE_W-1:0] data);
      drain_results();
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == CSR_TIMEOUT) cfg_timeout = data;
      else cfg_chunk = data;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic test_console_and_idle_ticks();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(ACK_START);
      send_ticks(2);
   endtask

   task automatic test_normal_frame();
      send_byte(HDR_NORMAL);
      send_byte(8'h00);
      send_byte(8'h03);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h5A);
   endtask

   task automatic test_empty_exception_frame();
      send_byte(HDR_EXCEPT);
      send_byte(8'h00);
      send_byte(8'h00);
   endtask

   task automatic test_chunk_acks();
      write_register(CSR_CHUNK, 8'd2);
      send_byte(HDR_EXCEPT);
      send_byte(8'h00);
      send_byte(8'h05);
      repeat (5) send_byte(BYTE_W'($urandom_range(255)));
   endtask

   task automatic test_timeout();
      write_register(CSR_TIMEOUT, 8'd3);
      send_byte(HDR_NORMAL);
      send_byte(8'h00);
      send_byte(8'h09);
      send_ticks(2);
      send_byte(8'hA5);
      send_ticks(3);
   endtask

   task automatic test_tick_limits();
      // timeout off: frame stays open
      write_register(CSR_TIMEOUT, 8'd0);
      send_byte(HDR_NORMAL);
      send_ticks(12);
      send_byte(8'h00);
      send_byte(8'h00);
      write_register(CSR_TIMEOUT, 8'd6);
      send_byte(HDR_EXCEPT);
      send_byte(8'h00);
      send_byte(8'h04);
      send_ticks(5);
      send_byte(8'h11);
      send_ticks(6);
   endtask

   task automatic test_chunk_wrap();
      // chunk size zero: no ack before the final payload item
      write_register(CSR_TIMEOUT, 8'd20);
      write_register(CSR_CHUNK, 8'd0);
      send_byte(HDR_NORMAL);
      send_byte(8'h00);
      send_byte(8'h0C);
      repeat (12) send_byte(BYTE_W'($urandom_range(255)));
   endtask

   task automatic send_frame(input bit broken);
      logic [LEN_W-1:0] flen;
      int               stop_at;
      int               k_max;
      if ($urandom_range(11) == 0) flen = '0;
      else if ($urandom_range(9) == 0) flen = LEN_W'($urandom_range(13, 40));
      else flen = LEN_W'($urandom_range(1, 12));
      stop_at = broken ? $urandom_range(0, flen + 1) : flen + 2;
      k_max = (cfg_timeout == 0 || cfg_timeout > 6) ? 5 : cfg_timeout - 1;
      send_byte(BYTE_W'($urandom_range(1, 2)));
      for (int i = 0; i < flen + 2 && i < stop_at; i++) begin
         if ($urandom_range(4) == 0) send_ticks($urandom_range(0, k_max));
         if (i == 0) send_byte(flen[15:8]);
         else if (i == 1) send_byte(flen[7:0]);
         else send_byte(BYTE_W'($urandom_range(255)));
      end
      if (broken && cfg_timeout != 0 && cfg_timeout <= 40) send_ticks(int'(cfg_timeout));
   endtask

   task automatic run_random_phase(input int src, input int snk,
                                   input logic [BYTE_W-1:0] tmo,
                                   input logic [BYTE_W-1:0] chk);
      int start;
      int r;
      write_register(CSR_TIMEOUT, tmo);
      write_register(CSR_CHUNK, chk);
      gap_pct   = src;
      stall_pct = snk;
      start     = item_count;
      while (item_count - start < PHASE_ITEMS) begin
         r = $urandom_range(99);
         if (r < 70) send_frame(1'b0);
         else if (r < 85) send_frame(1'b1);
         else begin
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(1)) send_byte(BYTE_W'($urandom_range(255)));
               else send_item(OP_TICK, BYTE_W'($urandom_range(255)));
            end
         end
      end
   endtask

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.op      = OP_BYTE;
      req_bus.rx_byte = '0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = CSR_TIMEOUT;
      csr_bus.data    = '0;
      rsp_bus.ready   = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_console_and_idle_ticks();
      test_normal_frame();
      test_empty_exception_frame();
      test_chunk_acks();
      test_timeout();
      test_tick_limits();
      gap_pct   = 17;
      stall_pct = 17;
      test_chunk_wrap();

      run_random_phase(0, 0, 8'd1, 8'd1);
      run_random_phase(55, 0, 8'd255, 8'd255);
      run_random_phase(0, 55, BYTE_W'($urandom_range(2, 10)), BYTE_W'($urandom_range(1, 6)));
      run_random_phase(17, 17, TIMEOUT_RESET, CHUNK_RESET);

      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/card_pkg.sv
sv/card_if.sv
sv/card_rsp_queue.sv
sv/chunked_ack_result_deframer.sv
test/tb_chunked_ack_result_deframer.sv
